// ----- rtl/core/dual_polarization_string_synth_top_macros.svh -----
`ifndef DUAL_POLARIZATION_STRING_SYNTH_TOP_MACROS_SVH
`define DUAL_POLARIZATION_STRING_SYNTH_TOP_MACROS_SVH

// implication checked in the next cycle
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the same cycle
`define DPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dps_pkg.sv -----
package dps_pkg;

  typedef logic signed [23:0] smp_t;
  typedef logic signed [17:0] coef_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PLUCK = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic [2:0] REG_LEN_V   = 3'd0;
  localparam logic [2:0] REG_LEN_H   = 3'd1;
  localparam logic [2:0] REG_GAIN_V  = 3'd2;
  localparam logic [2:0] REG_GAIN_H  = 3'd3;
  localparam logic [2:0] REG_TUNE_V  = 3'd4;
  localparam logic [2:0] REG_TUNE_H  = 3'd5;
  localparam logic [2:0] REG_STIFF   = 3'd6;
  localparam logic [2:0] REG_LEAK    = 3'd7;

  localparam logic signed [16:0] K_INV_SQRT2    = 17'sd46341;
  localparam logic [15:0]        K_TENSION_GAIN = 16'd55706;
  localparam logic [13:0]        K_PITCH        = 14'd9830;
  localparam logic signed [18:0] K_COEFF_CAP    = 19'sd49152;
  localparam logic [15:0]        K_TENSION_FLOOR = 16'd66;
  localparam logic signed [15:0] K_BRIDGE_H     = 16'sd14418;
  localparam logic [31:0]        K_ENERGY_KEEP  = 32'd4294537799;
  localparam logic [18:0]        K_ENERGY_ADD   = 19'd429497;
  localparam logic [31:0]        K_ONE_Q28      = 32'd268435456;

  function automatic smp_t sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -48'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  // y = c*(x - y1) + x1, Q2.21 samples, Q1.16 coefficient
  function automatic smp_t allpass(input coef_t c, input smp_t x, input smp_t x1,
                                   input smp_t y1);
    logic signed [24:0] diff;
    logic signed [42:0] prod;
    logic signed [47:0] acc;
    diff = $signed({x[23], x}) - $signed({y1[23], y1});
    prod = c * diff;
    acc = 48'(prod) + (48'(x1) <<< 16);
    return sat24(acc >>> 16);
  endfunction

endpackage

// ----- rtl/core/dps_cmd_if.sv -----
interface dps_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [11:0]        sample_index;
  logic signed [23:0] excite_sample;
  logic [15:0]        velocity;

  modport source (output valid, action, sample_index, excite_sample, velocity,
                  input ready);
  modport sink (input valid, action, sample_index, excite_sample, velocity,
                output ready);
endinterface

// ----- rtl/core/dps_res_if.sv -----
interface dps_res_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] bridge_sample;
  logic [31:0]        energy_level;

  modport source (output valid, bridge_sample, energy_level, input ready);
  modport sink (input valid, bridge_sample, energy_level, output ready);
endinterface

// ----- rtl/core/dps_ram.sv -----
module dps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/dual_polarization_string_synth_top.sv -----
// channel | dir | beat contents
// cmd     | in  | action, sample_index, excite_sample, velocity
// res     | out | bridge_sample, energy_level (one beat per tick)
// Tick: read, average/gain, dispersion, tuning + write-back + square, energy
//   products, result; the loop's registered memory read sets the start.
// Load: writes each line whose length covers sample_index. Pluck: a sweep zeroing both lines.
// Reset runs the same sweep over all MAX_DELAY addresses with cmd.ready low.
// A stalled result beat holds in its register; a tick waits only if it is still full.
module dual_polarization_string_synth_top import dps_pkg::*; #(
  parameter int MAX_DELAY = 4096
) (
  input  logic        clk,
  input  logic        rst,
  dps_cmd_if.sink     cmd,
  dps_res_if.source   res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam logic [16:0] DEPTH = 17'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_VSQ   = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_GAIN  = 4'd4;
  localparam logic [3:0] ST_DISP  = 4'd5;
  localparam logic [3:0] ST_TUNE  = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [11:0]        len_cfg  [2];
  logic [15:0]        gain_cfg [2];
  logic signed [16:0] tune_cfg [2];
  logic signed [16:0] stiff;
  logic [15:0]        leak;

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] head     [2];
  smp_t          avg_prev [2];
  smp_t          d_in     [2];
  smp_t          d_out    [2];
  smp_t          t_in     [2];
  smp_t          t_out    [2];
  smp_t          x        [2];
  smp_t          g        [2];
  smp_t          dv       [2];
  coef_t         coef     [2];
  logic [15:0]   tension;
  logic [31:0]   energy;
  logic [31:0]   vsq;
  smp_t          b;
  logic [33:0]   b2;
  logic [31:0]   ekeep;
  logic [20:0]   eadd;
  logic          zl;
  logic          rv;
  smp_t          bridge_o;
  logic [31:0]   energy_o;

  logic [16:0]        len_eff  [2];
  logic               load_hit [2];
  logic [AW-1:0]      mem_addr [2];
  logic               mem_we   [2];
  smp_t               mem_wdata[2];
  logic [23:0]        mem_rdata[2];
  logic [AW-1:0]      head_next[2];
  logic [16:0]        head_inc [2];
  logic signed [24:0] avg_sum  [2];
  logic signed [41:0] g_prod   [2];
  smp_t               g_val    [2];
  smp_t               d_val    [2];
  smp_t               t_val    [2];
  coef_t              coef_next[2];
  logic signed [18:0] coef_sum [2];
  logic               zero_len;
  logic               acc;
  logic signed [40:0] load_prod;
  smp_t               load_w;
  logic [29:0]        pitch_prod;
  logic [31:0]        decay_prod;
  logic [31:0]        pluck_prod;
  logic signed [39:0] bh_prod;
  logic signed [47:0] bb;
  logic [63:0]        keep_prod;
  logic [52:0]        add_prod;
  logic [32:0]        e_sum;
  logic [31:0]        e_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg[0]  <= 12'd100;
      len_cfg[1]  <= 12'd100;
      gain_cfg[0] <= '0;
      gain_cfg[1] <= '0;
      tune_cfg[0] <= '0;
      tune_cfg[1] <= '0;
      stiff       <= '0;
      leak        <= 16'd65000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEN_V:  len_cfg[0]  <= cfg_data[11:0];
        REG_LEN_H:  len_cfg[1]  <= cfg_data[11:0];
        REG_GAIN_V: gain_cfg[0] <= cfg_data[15:0];
        REG_GAIN_H: gain_cfg[1] <= cfg_data[15:0];
        REG_TUNE_V: tune_cfg[0] <= cfg_data;
        REG_TUNE_H: tune_cfg[1] <= cfg_data;
        REG_STIFF:  stiff       <= cfg_data;
        REG_LEAK:   leak        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cmd.ready         = (state == ST_IDLE);
  assign acc               = cmd.valid && cmd.ready;
  assign res.valid         = rv;
  assign res.bridge_sample = bridge_o;
  assign res.energy_level  = energy_o;

  assign zero_len   = (len_eff[0] == '0) || (len_eff[1] == '0);
  assign load_prod  = cmd.excite_sample * K_INV_SQRT2;
  assign load_w     = sat24(48'(load_prod >>> 16));
  assign pitch_prod = tension * K_PITCH;
  assign decay_prod = tension * leak;
  assign pluck_prod = vsq[31:16] * K_TENSION_GAIN;
  assign bh_prod    = x[1] * K_BRIDGE_H;
  assign bb         = b * b;
  assign keep_prod  = energy * K_ENERGY_KEEP;
  assign add_prod   = b2 * K_ENERGY_ADD;
  assign e_sum      = {1'b0, ekeep} + {12'd0, eadd};
  assign e_sat      = e_sum[32] ? 32'hffffffff : e_sum[31:0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      len_eff[l]  = ({5'd0, len_cfg[l]} > DEPTH) ? DEPTH : {5'd0, len_cfg[l]};
      load_hit[l] = {5'd0, cmd.sample_index} < len_eff[l];
      head_inc[l] = 17'(head[l]) + 17'd1;
      head_next[l] = (head_inc[l] >= len_eff[l]) ? '0 : head_inc[l][AW-1:0];
      avg_sum[l]  = $signed({mem_rdata[l][23], mem_rdata[l]})
                  + $signed({avg_prev[l][23], avg_prev[l]});
      g_prod[l]   = $signed(avg_sum[l][24:1]) * $signed({1'b0, gain_cfg[l]});
      g_val[l]    = sat24(48'(g_prod[l] >>> 16));
      d_val[l]    = allpass(coef_t'(stiff), g[l], d_in[l], d_out[l]);
      t_val[l]    = allpass(coef[l], dv[l], t_in[l], t_out[l]);
      coef_sum[l] = 19'(tune_cfg[l]) + $signed({5'd0, pitch_prod[29:16]});
      if (tension > K_TENSION_FLOOR) begin
        coef_next[l] = (coef_sum[l] > K_COEFF_CAP) ? coef_t'(K_COEFF_CAP)
                                                   : coef_sum[l][17:0];
      end else begin
        coef_next[l] = coef_t'(tune_cfg[l]);
      end

      mem_addr[l]  = head[l];
      mem_we[l]    = 1'b0;
      mem_wdata[l] = t_val[l];
      case (state)
        ST_CLEAR: begin
          mem_addr[l]  = clr_addr;
          mem_we[l]    = 1'b1;
          mem_wdata[l] = '0;
        end
        ST_IDLE: begin
          if (acc && cmd.action == ACT_LOAD) begin
            mem_addr[l]  = AW'(cmd.sample_index);
            mem_we[l]    = load_hit[l];
            mem_wdata[l] = load_w;
          end
        end
        ST_TUNE: mem_we[l] = 1'b1;
        default: ;
      endcase
    end
  end

  dps_ram #(.WIDTH(24), .DEPTH(MAX_DELAY)) u_line_v (
    .clk(clk), .we(mem_we[0]), .addr(mem_addr[0]), .wdata(mem_wdata[0]),
    .rdata(mem_rdata[0])
  );

  dps_ram #(.WIDTH(24), .DEPTH(MAX_DELAY)) u_line_h (
    .clk(clk), .we(mem_we[1]), .addr(mem_addr[1]), .wdata(mem_wdata[1]),
    .rdata(mem_rdata[1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      tension  <= '0;
      energy   <= '0;
      rv       <= 1'b0;
      zl       <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        head[l]     <= '0;
        avg_prev[l] <= '0;
        d_in[l]     <= '0;
        d_out[l]    <= '0;
        t_in[l]     <= '0;
        t_out[l]    <= '0;
      end
    end else begin
      if (res.ready && state != ST_OUT) begin
        rv <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (cmd.action)
              ACT_TICK: begin
                zl    <= zero_len;
                state <= zero_len ? ST_OUT : ST_RD;
              end
              ACT_PLUCK: begin
                vsq    <= cmd.velocity * cmd.velocity;
                energy <= K_ONE_Q28;
                for (int l = 0; l < 2; l++) begin
                  head[l]     <= '0;
                  avg_prev[l] <= '0;
                  d_in[l]     <= '0;
                  d_out[l]    <= '0;
                  t_in[l]     <= '0;
                  t_out[l]    <= '0;
                end
                state <= ST_VSQ;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_VSQ: begin
          tension  <= pluck_prod[31:16];
          clr_addr <= '0;
          state    <= ST_CLEAR;
        end
        ST_RD: begin
          coef[0] <= coef_next[0];
          coef[1] <= coef_next[1];
          if (tension > K_TENSION_FLOOR) begin
            tension <= decay_prod[31:16];
          end
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          for (int l = 0; l < 2; l++) begin
            x[l]        <= mem_rdata[l];
            avg_prev[l] <= mem_rdata[l];
            g[l]        <= g_val[l];
          end
          state <= ST_DISP;
        end
        ST_DISP: begin
          for (int l = 0; l < 2; l++) begin
            d_in[l]  <= g[l];
            d_out[l] <= d_val[l];
            dv[l]    <= d_val[l];
          end
          b     <= sat24(48'(x[0]) + 48'(bh_prod >>> 16));
          state <= ST_TUNE;
        end
        ST_TUNE: begin
          for (int l = 0; l < 2; l++) begin
            t_in[l]  <= dv[l];
            t_out[l] <= t_val[l];
            head[l]  <= head_next[l];
          end
          b2    <= bb[47:14];
          state <= ST_SQ;
        end
        ST_SQ: begin
          ekeep <= keep_prod[63:32];
          eadd  <= add_prod[52:32];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!rv || res.ready) begin
            rv <= 1'b1;
            if (zl) begin
              bridge_o <= '0;
              energy_o <= energy;
            end else begin
              bridge_o <= b;
              energy_o <= e_sat;
              energy   <= e_sat;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/dps_checker.sv -----
`include "dual_polarization_string_synth_top_macros.svh"

module dps_checker import dps_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [1:0]  cmd_action,
  input logic        res_valid,
  input logic        res_ready,
  input logic [23:0] res_bridge,
  input logic [31:0] res_energy
);

  `DPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bridge) && $stable(res_energy), "result beat changed while stalled")
  `DPS_ASSERT_NEXT(a_tick_busy, cmd_valid && cmd_ready && cmd_action == ACT_TICK, !cmd_ready, "ready right after tick")
  `DPS_ASSERT_NEXT(a_pluck_busy, cmd_valid && cmd_ready && cmd_action == ACT_PLUCK, !cmd_ready, "ready right after pluck")
  `DPS_ASSERT_NOW(a_load_silent, $past(cmd_valid && cmd_ready && cmd_action == ACT_LOAD && !res_valid), !res_valid, "load produced a result")

endmodule

bind dual_polarization_string_synth_top dps_checker u_dps_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .cmd_action(cmd.action),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_bridge(res.bridge_sample),
  .res_energy(res.energy_level)
);
